/* sv/htpr_pkg.sv */
`timescale 1ns / 1ps

package htpr_pkg;

   localparam int WORDS_DEFAULT = 4;
   localparam int WORD_W        = 64;
   localparam int COUNT_W       = 6;
   localparam int TICK_W        = 16;
   localparam int BYTE_W        = 8;
   localparam int INDEX_W       = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'd170;
   localparam logic [BYTE_W-1:0] TAIL_RESET    = 8'd85;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_TICK = 2'd1,
      CMD_TAKE = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_TAIL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] tail_byte;
      logic [TICK_W-1:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic              packet_done;
      logic              frame_error;
      logic              timed_out;
      logic              ready_flag;
      logic [WORD_W-1:0] word_value;
      logic              read_valid;
      logic [1:0]        phase;
   } rsp_type;

endpackage

/* sv/htpr_core.sv */
`timescale 1ns / 1ps

module htpr_core #(
   parameter int WORDS = htpr_pkg::WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      command,
   input  logic [htpr_pkg::BYTE_W-1:0]     rx_byte,
   input  logic [htpr_pkg::INDEX_W-1:0]    word_index,
   input  htpr_pkg::cfg_type               cfg,
   output htpr_pkg::rsp_type               result
);
   import htpr_pkg::*;

   localparam int WIDX = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [COUNT_W-1:0] LAST_BYTE = COUNT_W'(WORDS * 8 - 1);
   localparam logic [INDEX_W-1:0] WORDS_LIMIT = INDEX_W'(WORDS);

   cmd_type              cmd;
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TICK_W-1:0]    tick_ff, tick_in, tick_next;
   logic                 ready_ff, ready_in;
   logic                 tail_match;
   logic                 timeout_hit;
   logic                 write_en;
   logic                 copy_en;
   logic [WIDX-1:0]      write_sel;
   logic [2:0]           byte_sel;
   logic [WORD_W-1:0]    write_words_ff [WORDS];
   logic [WORD_W-1:0]    read_words_ff [WORDS];

   assign cmd         = cmd_type'(command);
   assign tail_match  = (rx_byte == cfg.tail_byte);
   assign tick_next   = (tick_ff != TICK_MAX) ? tick_ff + 16'd1 : tick_ff;
   assign timeout_hit = (tick_next > cfg.timeout_limit);
   assign write_sel   = WIDX'(count_ff[COUNT_W-1:3]);
   assign byte_sel    = count_ff[2:0];
   assign write_en    = accept && (cmd == CMD_BYTE) && (phase_ff == PH_DATA);
   assign copy_en     = accept && (cmd == CMD_BYTE) && (phase_ff == PH_TAIL) && tail_match;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      tick_in  = tick_ff;
      ready_in = ready_ff;
      unique case (cmd)
         CMD_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (rx_byte == cfg.header_byte) begin
                     phase_in = PH_DATA;
                     count_in = '0;
                     tick_in  = '0;
                  end
               end
               PH_DATA: begin
                  if (count_ff == LAST_BYTE) begin
                     phase_in = PH_TAIL;
                     count_in = '0;
                  end else begin
                     count_in = count_ff + 6'd1;
                  end
               end
               PH_TAIL: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  tick_in  = '0;
                  ready_in = tail_match;
               end
               default: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  tick_in  = '0;
                  ready_in = 1'b0;
               end
            endcase
         end
         CMD_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (timeout_hit) begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  tick_in  = '0;
                  ready_in = 1'b0;
               end else begin
                  tick_in = tick_next;
               end
            end
         end
         CMD_TAKE: begin
            ready_in = 1'b0;
         end
         CMD_READ: begin
         end
      endcase
   end

   always_comb begin
      result             = '0;
      result.ready_flag  = ready_ff;
      result.phase       = phase_in;
      unique case (cmd)
         CMD_BYTE: begin
            result.packet_done = (phase_ff == PH_TAIL) && tail_match;
            result.frame_error = ((phase_ff == PH_TAIL) && !tail_match)
                                 || ((phase_ff != PH_IDLE) && (phase_ff != PH_DATA)
                                     && (phase_ff != PH_TAIL));
         end
         CMD_TICK: begin
            result.timed_out = (phase_ff != PH_IDLE) && timeout_hit;
         end
         CMD_TAKE: begin
         end
         CMD_READ: begin
            if (word_index < WORDS_LIMIT) begin
               result.read_valid = 1'b1;
               result.word_value = read_words_ff[word_index[WIDX-1:0]];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         tick_ff  <= '0;
         ready_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tick_ff  <= tick_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         write_words_ff[write_sel][{byte_sel, 3'b000} +: BYTE_W] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            read_words_ff[i] <= '0;
         end
      end else if (copy_en) begin
         for (int i = 0; i < WORDS; i++) begin
            read_words_ff[i] <= write_words_ff[i];
         end
      end
   end

endmodule

/* sv/htpr_out_skid.sv */
`timescale 1ns / 1ps

module htpr_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  htpr_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output htpr_pkg::rsp_type out_data
);
   import htpr_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

/* sv/header_tail_packet_receiver_top.sv */
`timescale 1ns / 1ps

// Frame receiver for a header byte, WORDS*8 payload bytes and a tail byte, with a tick-driven
// timeout. One request is accepted every clock cycle while req_ready is high: the whole
// per-request step (phase update, payload byte write, tail check, timeout compare, read
// buffer select) is one pass of logic from the stored receiver state to a result register
// in the output buffer. A two-entry output buffer keeps req_ready high while one response
// waits, and drops it only when two are held. Configuration writes are taken in any cycle
// and must be made while no request is in flight.

module header_tail_packet_receiver_top #(
   parameter int WORDS = htpr_pkg::WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic [htpr_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic [htpr_pkg::INDEX_W-1:0]       req_word_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_packet_done,
   output logic                               rsp_frame_error,
   output logic                               rsp_timed_out,
   output logic                               rsp_ready_flag,
   output logic [htpr_pkg::WORD_W-1:0]        rsp_word_value,
   output logic                               rsp_read_valid,
   output logic [1:0]                         rsp_phase,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [htpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [htpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import htpr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   rsp_type step_result;
   rsp_type out_data;
   logic    accept;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER:  cfg_in.header_byte   = csr_wdata[BYTE_W-1:0];
            CSR_TAIL:    cfg_in.tail_byte     = csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT: cfg_in.timeout_limit = csr_wdata[TICK_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte   <= HEADER_RESET;
         cfg_ff.tail_byte     <= TAIL_RESET;
         cfg_ff.timeout_limit <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   htpr_core #(
      .WORDS(WORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .rx_byte    (req_rx_byte),
      .word_index (req_word_index),
      .cfg        (cfg_ff),
      .result     (step_result)
   );

   htpr_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_packet_done = out_data.packet_done;
   assign rsp_frame_error = out_data.frame_error;
   assign rsp_timed_out   = out_data.timed_out;
   assign rsp_ready_flag  = out_data.ready_flag;
   assign rsp_word_value  = out_data.word_value;
   assign rsp_read_valid  = out_data.read_valid;
   assign rsp_phase       = out_data.phase;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import htpr_pkg::*;

   localparam int WORDS       = WORDS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int PRINT_CAP   = 50;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      cmd_type           cmd;
      logic [BYTE_W-1:0] rx;
      logic [INDEX_W-1:0] idx;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_command = CMD_BYTE;
   logic [BYTE_W-1:0]       req_rx_byte = '0;
   logic [INDEX_W-1:0]      req_word_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_packet_done;
   logic                    rsp_frame_error;
   logic                    rsp_timed_out;
   logic                    rsp_ready_flag;
   logic [WORD_W-1:0]       rsp_word_value;
   logic                    rsp_read_valid;
   logic [1:0]              rsp_phase;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Receiver state as the checker sees it.
   cfg_type           cfg;
   phase_type         rx_ph;
   logic [COUNT_W-1:0] byte_cnt;
   logic [TICK_W-1:0] tick_cnt;
   logic              rdy;
   logic [WORD_W-1:0] wr_buf [WORDS];
   logic [WORD_W-1:0] rd_buf [WORDS];

   req_item_type req_backlog[$];
   rsp_type      due_rsp[$];
   req_item_type req_cur;
   int      req_gap = 0;
   int      rsp_stall = 0;
   bit      pace_on = 1'b1;
   int      item_count = 0;
   int      rsp_count = 0;
   int      errors = 0;
   int      quiet_cycles = 0;
   int      frames_done = 0;
   int      frames_bad = 0;
   int      timeouts = 0;
   int      word_reads = 0;
   int      cfg_phases = 0;

   header_tail_packet_receiver_top #(
      .WORDS(WORDS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .req_word_index (req_word_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_packet_done(rsp_packet_done),
      .rsp_frame_error(rsp_frame_error),
      .rsp_timed_out  (rsp_timed_out),
      .rsp_ready_flag (rsp_ready_flag),
      .rsp_word_value (rsp_word_value),
      .rsp_read_valid (rsp_read_valid),
      .rsp_phase      (rsp_phase),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void leave_frame(bit drop_ready);
      rx_ph = PH_IDLE;
      byte_cnt = '0;
      tick_cnt = '0;
      if (drop_ready) begin
         rdy = 1'b0;
      end
   endfunction

   function automatic rsp_type receiver_step(cmd_type cmd, logic [BYTE_W-1:0] rx,
                                             logic [INDEX_W-1:0] idx);
      rsp_type r;
      int w;
      int sh;
      r = '0;
      r.ready_flag = rdy;
      case (cmd)
         CMD_BYTE: begin
            case (rx_ph)
               PH_IDLE: begin
                  if (rx == cfg.header_byte) begin
                     rx_ph = PH_DATA;
                     byte_cnt = '0;
                     tick_cnt = '0;
                  end
               end
               PH_DATA: begin
                  w = (int'(byte_cnt) >> 3) % WORDS;
                  sh = 8 * int'(byte_cnt[2:0]);
                  wr_buf[w][sh +: 8] = rx;
                  byte_cnt = byte_cnt + 1'b1;
                  if (byte_cnt == 0 || byte_cnt >= WORDS * 8) begin
                     rx_ph = PH_TAIL;
                     byte_cnt = '0;
                  end
               end
               PH_TAIL: begin
                  if (rx == cfg.tail_byte) begin
                     rd_buf = wr_buf;
                     rdy = 1'b1;
                     leave_frame(1'b0);
                     r.packet_done = 1'b1;
                  end else begin
                     leave_frame(1'b1);
                     r.frame_error = 1'b1;
                  end
               end
               default: begin
                  leave_frame(1'b1);
                  r.frame_error = 1'b1;
               end
            endcase
         end
         CMD_TICK: begin
            if (rx_ph != PH_IDLE) begin
               if (tick_cnt != TICK_MAX) begin
                  tick_cnt = tick_cnt + 1'b1;
               end
               if (tick_cnt > cfg.timeout_limit) begin
                  leave_frame(1'b1);
                  r.timed_out = 1'b1;
               end
            end
         end
         CMD_TAKE: begin
            rdy = 1'b0;
         end
         default: begin
            if (idx < WORDS) begin
               w = int'(idx);
               r.word_value = rd_buf[w];
               r.read_valid = 1'b1;
            end
         end
      endcase
      r.phase = rx_ph;
      return r;
   endfunction

   function automatic int draw_pause();
      if (!pace_on || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic report(input string msg);
      if (errors < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
      if (got !== want) begin
         report($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            due_rsp.push_back(receiver_step(req_cur.cmd, req_cur.rx, req_cur.idx));
            req_gap = draw_pause();
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_cur = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= req_cur.cmd;
               req_rx_byte <= req_cur.rx;
               req_word_index <= req_cur.idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (due_rsp.size() == 0) begin
               report("response arrived with no request outstanding");
            end else begin
               want = due_rsp.pop_front();
               check_field("packet_done", 64'(rsp_packet_done), 64'(want.packet_done));
               check_field("frame_error", 64'(rsp_frame_error), 64'(want.frame_error));
               check_field("timed_out", 64'(rsp_timed_out), 64'(want.timed_out));
               check_field("ready_flag", 64'(rsp_ready_flag), 64'(want.ready_flag));
               check_field("word_value", rsp_word_value, want.word_value);
               check_field("read_valid", 64'(rsp_read_valid), 64'(want.read_valid));
               check_field("phase", 64'(rsp_phase), 64'(want.phase));
               frames_done += int'(want.packet_done);
               frames_bad += int'(want.frame_error);
               timeouts += int'(want.timed_out);
               word_reads += int'(want.read_valid);
            end
            rsp_stall = draw_pause();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** header_tail_packet_receiver_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_req(input cmd_type cmd, input logic [BYTE_W-1:0] rx,
                            input logic [INDEX_W-1:0] idx);
      req_backlog.push_back('{cmd, rx, idx});
      item_count++;
   endtask

   task automatic wait_drained();
      while (rsp_count < item_count) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (index)
         CSR_HEADER:  cfg.header_byte = data[BYTE_W-1:0];
         CSR_TAIL:    cfg.tail_byte = data[BYTE_W-1:0];
         CSR_TIMEOUT: cfg.timeout_limit = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tl,
                             input logic [TICK_W-1:0] lim);
      wait_drained();
      write_csr(CSR_HEADER, {8'($urandom_range(0, 255)), hdr});
      write_csr(CSR_TAIL, {8'($urandom_range(0, 255)), tl});
      write_csr(CSR_TIMEOUT, lim);
      write_csr(CSR_SPARE, 16'($urandom_range(0, 65535)));
      cfg_phases++;
   endtask

   function automatic logic [BYTE_W-1:0] payload_byte();
      case ($urandom_range(0, 9))
         0: return cfg.header_byte;
         1: return cfg.tail_byte;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_frame(input bit good_tail);
      int ticks;
      ticks = 0;
      queue_req(CMD_BYTE, cfg.header_byte, 4'($urandom));
      for (int i = 0; i < WORDS * 8; i++) begin
         if ($urandom_range(0, 15) == 0 && ticks < cfg.timeout_limit) begin
            queue_req(CMD_TICK, 8'($urandom), 4'($urandom));
            ticks++;
         end
         queue_req(CMD_BYTE, payload_byte(), 4'($urandom));
      end
      if (good_tail) begin
         queue_req(CMD_BYTE, cfg.tail_byte, 4'($urandom));
      end else begin
         queue_req(CMD_BYTE, cfg.tail_byte ^ 8'($urandom_range(1, 255)), 4'($urandom));
      end
   endtask

   task automatic queue_mix(input int target);
      int start;
      int n;
      start = item_count;
      while (item_count - start < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               queue_frame($urandom_range(0, 4) != 0);
               if ($urandom_range(0, 1) == 0) begin
                  queue_req(CMD_READ, 8'($urandom), 4'($urandom_range(0, WORDS - 1)));
               end
               if ($urandom_range(0, 2) == 0) begin
                  queue_req(CMD_TAKE, 8'($urandom), 4'($urandom));
               end
            end
            11, 12: begin
               queue_req(CMD_BYTE, cfg.header_byte, 4'($urandom));
               n = $urandom_range(0, WORDS * 8);
               repeat (n) queue_req(CMD_BYTE, payload_byte(), 4'($urandom));
               n = (cfg.timeout_limit <= 48) ? int'(cfg.timeout_limit) + $urandom_range(0, 1)
                                             : $urandom_range(1, 8);
               repeat (n) queue_req(CMD_TICK, 8'($urandom), 4'($urandom));
               queue_req(CMD_BYTE, payload_byte(), 4'($urandom));
            end
            13, 14, 15, 16: begin
               n = $urandom_range(1, 6);
               repeat (n) queue_req(cmd_type'($urandom_range(0, 3)), 8'($urandom),
                                    4'($urandom));
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) queue_req(CMD_READ, 8'($urandom), 4'($urandom_range(0, 15)));
               queue_req(CMD_TAKE, 8'($urandom), 4'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      cfg = {HEADER_RESET, TAIL_RESET, TIMEOUT_RESET};
      leave_frame(1'b1);
      for (int i = 0; i < WORDS; i++) begin
         wr_buf[i] = '0;
         rd_buf[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_req(CMD_READ, 8'h00, 4'd0);
      queue_req(CMD_READ, 8'hFF, 4'(WORDS));
      queue_req(CMD_READ, 8'h00, 4'd15);
      queue_req(CMD_TAKE, 8'h00, 4'd0);
      queue_req(CMD_TICK, 8'h00, 4'd0);
      queue_req(CMD_BYTE, 8'h00, 4'd0);
      queue_req(CMD_BYTE, 8'hFF, 4'd15);
      queue_req(CMD_BYTE, cfg.header_byte, 4'd0);
      for (int i = 0; i < WORDS * 8; i++) begin
         if (i == 16) begin
            queue_req(CMD_TICK, 8'h00, 4'd0);
         end
         case (i)
            0: queue_req(CMD_BYTE, cfg.header_byte, 4'd0);
            1: queue_req(CMD_BYTE, cfg.tail_byte, 4'd0);
            2: queue_req(CMD_BYTE, 8'h00, 4'd0);
            3: queue_req(CMD_BYTE, 8'hFF, 4'd0);
            default: queue_req(CMD_BYTE, 8'($urandom), 4'd0);
         endcase
      end
      queue_req(CMD_BYTE, cfg.tail_byte, 4'd0);
      for (int i = 0; i < WORDS; i++) begin
         queue_req(CMD_READ, 8'h00, 4'(i));
      end
      queue_req(CMD_TAKE, 8'h00, 4'd0);
      queue_req(CMD_TAKE, 8'h00, 4'd0);

      set_config(8'h00, 8'hFF, 16'd0);
      queue_mix(180);

      set_config(8'hFF, 8'h00, 16'd65534);
      queue_mix(180);

      for (int p = 0; p < 6; p++) begin
         logic [BYTE_W-1:0] hdr;
         hdr = 8'($urandom);
         set_config(hdr, ($urandom_range(0, 3) == 0) ? hdr : 8'($urandom),
                    16'($urandom_range(0, 40)));
         pace_on = (p != 5);
         queue_mix(180);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (due_rsp.size() != 0) begin
         report($sformatf("%0d responses never arrived", due_rsp.size()));
      end
      $display("Ran %0d requests over %0d register settings with random pacing.",
               item_count, cfg_phases + 1);
      $display("Saw %0d good frames, %0d frame errors, %0d timeouts, %0d word reads.",
               frames_done, frames_bad, timeouts, word_reads);
      if (errors == 0) begin
         $display("** header_tail_packet_receiver_top: PASSED **");
      end else begin
         $display("** header_tail_packet_receiver_top: FAILED **");
      end
      $finish;
   end

endmodule
